// ----- design/lens_distortion_point_mapper_macros.svh -----
// Assertion macros for the lens distortion point mapper checker
`ifndef LENS_DISTORTION_POINT_MAPPER_MACROS_SVH
`define LENS_DISTORTION_POINT_MAPPER_MACROS_SVH

// same-cycle implication, disabled in reset
`define LDM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define LDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// next-cycle implication, live during reset
`define LDM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset check failed");

`endif

// ----- design/ldm_pkg.sv -----
`timescale 1ns / 1ps
// Package: payload types, register codes and fixed-point helpers of the point mapper
package ldm_pkg;

    typedef logic signed [63:0] t_q;
    typedef logic signed [33:0] t_d;

    localparam t_q Q_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam t_q Q_ONE = 64'sh0000_0001_0000_0000;

    localparam int DIV_QBITS          = 62;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = DIV_QBITS / DIV_BITS_PER_STAGE;

    typedef enum logic [2:0] {
        CFG_FOCAL_X   = 3'd0,
        CFG_FOCAL_Y   = 3'd1,
        CFG_PRINCIPAL = 3'd2,
        CFG_K1        = 3'd3,
        CFG_K2        = 3'd4,
        CFG_K3        = 3'd5,
        CFG_P1        = 3'd6,
        CFG_P2        = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_ldm_in;

    typedef struct packed {
        logic signed [31:0] distorted_x;
        logic signed [31:0] distorted_y;
        logic               saturated;
    } t_ldm_out;

    typedef struct packed {
        logic sat;
        t_q   val;
    } t_qres;

    // saturating add of two internal values
    function automatic t_qres qadd(input t_q a, input t_q b);
        logic signed [64:0] s;
        t_qres              r;
        s = 65'(a) + 65'(b);
        if (s > 65'(Q_LIM)) begin
            r.sat = 1'b1;
            r.val = Q_LIM;
        end else if (s < -65'(Q_LIM)) begin
            r.sat = 1'b1;
            r.val = -Q_LIM;
        end else begin
            r.sat = 1'b0;
            r.val = s[63:0];
        end
        return r;
    endfunction

endpackage

// ----- design/ldm_qmul.sv -----
`timescale 1ns / 1ps
// Pipelined saturating fixed-point multiplier, several lanes plus a sideband
module ldm_qmul
    import ldm_pkg::*;
#(
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_q    [LANES-1:0]       i_a,
    input  t_q    [LANES-1:0]       i_b,
    input  logic  [SIDE_W-1:0]      i_side,
    output logic                    o_valid,
    output t_q    [LANES-1:0]       o_p,
    output logic  [LANES-1:0]       o_sat,
    output logic  [SIDE_W-1:0]      o_side
);

    localparam int NSTG = 5;

    logic [61:0]        r1_ma  [LANES];
    logic [61:0]        r1_mb  [LANES];
    logic               r1_neg [LANES];
    logic [61:0]        r2_p00 [LANES];
    logic [61:0]        r2_p01 [LANES];
    logic [61:0]        r2_p10 [LANES];
    logic [61:0]        r2_p11 [LANES];
    logic               r2_neg [LANES];
    logic [62:0]        r3_mid [LANES];
    logic [61:0]        r3_p00 [LANES];
    logic [61:0]        r3_p11 [LANES];
    logic               r3_neg [LANES];
    logic [61:0]        r4_mag [LANES];
    logic               r4_sat [LANES];
    logic               r4_neg [LANES];
    t_q                 r5_p   [LANES];
    logic               r5_sat [LANES];
    logic [NSTG-1:0]    r_vld;
    logic [SIDE_W-1:0]  r_side [NSTG];

    logic [61:0]        n1_ma  [LANES];
    logic [61:0]        n1_mb  [LANES];
    logic [61:0]        n4_mag [LANES];
    logic               n4_sat [LANES];
    t_q                 n5_p   [LANES];

    always_comb begin
        t_q          na;
        t_q          nb;
        logic [123:0] sum;
        t_q          m;
        for (int l = 0; l < LANES; l++) begin
            na = -i_a[l];
            nb = -i_b[l];
            n1_ma[l] = i_a[l][63] ? na[61:0] : i_a[l][61:0];
            n1_mb[l] = i_b[l][63] ? nb[61:0] : i_b[l][61:0];
            sum = {r3_p11[l], 62'b0} + 124'({r3_mid[l], 31'b0}) + 124'(r3_p00[l]);
            n4_sat[l] = |sum[123:94];
            n4_mag[l] = n4_sat[l] ? Q_LIM[61:0] : sum[93:32];
            m = {2'b00, r4_mag[l]};
            n5_p[l] = r4_neg[l] ? -m : m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < NSTG; s++) begin
                r_side[s] <= r_side[s-1];
            end
            for (int l = 0; l < LANES; l++) begin
                r1_ma[l]  <= n1_ma[l];
                r1_mb[l]  <= n1_mb[l];
                r1_neg[l] <= i_a[l][63] ^ i_b[l][63];
                r2_p00[l] <= r1_ma[l][30:0] * r1_mb[l][30:0];
                r2_p01[l] <= r1_ma[l][30:0] * r1_mb[l][61:31];
                r2_p10[l] <= r1_ma[l][61:31] * r1_mb[l][30:0];
                r2_p11[l] <= r1_ma[l][61:31] * r1_mb[l][61:31];
                r2_neg[l] <= r1_neg[l];
                r3_mid[l] <= 63'(r2_p01[l]) + 63'(r2_p10[l]);
                r3_p00[l] <= r2_p00[l];
                r3_p11[l] <= r2_p11[l];
                r3_neg[l] <= r2_neg[l];
                r4_mag[l] <= n4_mag[l];
                r4_sat[l] <= n4_sat[l];
                r4_neg[l] <= r3_neg[l];
                r5_p[l]   <= n5_p[l];
                r5_sat[l] <= r4_sat[l];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_p[l]   = r5_p[l];
            o_sat[l] = r5_sat[l];
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_side  = r_side[NSTG-1];

endmodule

// ----- design/ldm_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider for the normalizing step, several lanes
module ldm_div
    import ldm_pkg::*;
#(
    parameter int LANES = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_d   [LANES-1:0]        i_d,
    input  logic [LANES-1:0][31:0]  i_f,
    output logic                    o_valid,
    output t_q   [LANES-1:0]        o_q,
    output logic [LANES-1:0]        o_sat
);

    localparam int NS = DIV_STAGES;

    logic [31:0]           r_rem [NS+1][LANES];
    logic [DIV_QBITS-1:0]  r_sh  [NS+1][LANES];
    logic [DIV_QBITS-1:0]  r_qt  [NS+1][LANES];
    logic                  r_neg [NS+1][LANES];
    logic                  r_sat [NS+1][LANES];
    logic [NS+1:0]         r_vld;
    t_q                    r_out [LANES];
    logic                  r_osat [LANES];

    logic [31:0]           n_rem [NS+1][LANES];
    logic [DIV_QBITS-1:0]  n_sh  [NS+1][LANES];
    logic [DIV_QBITS-1:0]  n_qt  [NS+1][LANES];
    logic                  n_sat0 [LANES];
    t_q                    n_out [LANES];

    function automatic logic [31:0] feff(input logic [31:0] f);
        return (f == 32'd0) ? 32'd1 : f;
    endfunction

    always_comb begin
        t_d           nd;
        logic [32:0]  m;
        logic [31:0]  fe;
        logic [31:0]  rem;
        logic [DIV_QBITS-1:0] sh;
        logic [DIV_QBITS-1:0] qt;
        logic [32:0]  t;
        t_q           qm;
        for (int l = 0; l < LANES; l++) begin
            fe = feff(i_f[l]);
            nd = -i_d[l];
            m  = i_d[l][33] ? nd[32:0] : i_d[l][32:0];
            n_rem[0][l] = {29'b0, m[32:30]};
            n_sh[0][l]  = {m[29:0], 32'b0};
            n_qt[0][l]  = '0;
            n_sat0[l]   = ({29'b0, m[32:30]} >= fe);
            for (int s = 1; s <= NS; s++) begin
                rem = r_rem[s-1][l];
                sh  = r_sh[s-1][l];
                qt  = r_qt[s-1][l];
                for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
                    t  = {rem, sh[DIV_QBITS-1]};
                    sh = {sh[DIV_QBITS-2:0], 1'b0};
                    if (t >= {1'b0, fe}) begin
                        rem = 32'(t - {1'b0, fe});
                        qt  = {qt[DIV_QBITS-2:0], 1'b1};
                    end else begin
                        rem = t[31:0];
                        qt  = {qt[DIV_QBITS-2:0], 1'b0};
                    end
                end
                n_rem[s][l] = rem;
                n_sh[s][l]  = sh;
                n_qt[s][l]  = qt;
            end
            qm = r_sat[NS][l] ? Q_LIM : t_q'({2'b00, r_qt[NS][l]});
            n_out[l] = r_neg[NS][l] ? -qm : qm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_neg[0][l] <= i_d[l][33];
                r_sat[0][l] <= n_sat0[l];
                for (int s = 0; s <= NS; s++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_sh[s][l]  <= n_sh[s][l];
                    r_qt[s][l]  <= n_qt[s][l];
                end
                for (int s = 1; s <= NS; s++) begin
                    r_neg[s][l] <= r_neg[s-1][l];
                    r_sat[s][l] <= r_sat[s-1][l];
                end
                r_out[l]  <= n_out[l];
                r_osat[l] <= r_sat[NS][l];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_q[l]   = r_out[l];
            o_sat[l] = r_osat[l];
        end
    end

    assign o_valid = r_vld[NS+1];

endmodule

// ----- design/lens_distortion_point_mapper.sv -----
`timescale 1ns / 1ps
// Top level: Brown-Conrady distortion of one Q16.16 point per clock unless the output stalls
//
//  channel   direction  handshake                payload
//  in        input      i_in_valid / o_in_stall  i_in_data  (point_x, point_y)
//  out       output     o_out_valid / i_out_stall o_out_data (distorted_x/y, saturated)
//  cfg       input      i_cfg_we                 i_cfg_index, i_cfg_data
//
// One point per clock sustained while the output is not stalled. Pipeline: the normalizing
// divider (2 quotient bits per stage), six multiplier passes of 5 stages, five add stages,
// one output register.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
// A stalled output beat holds; the pipeline keeps moving while its last stage is empty.
module lens_distortion_point_mapper
    import ldm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_ldm_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_ldm_out    o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    function automatic t_q coef_q(input logic [31:0] c);
        return {{24{c[31]}}, c, 8'b0};
    endfunction

    function automatic t_q coef_q2(input logic [31:0] c);
        return {{23{c[31]}}, c, 9'b0};
    endfunction

    function automatic logic [32:0] to_out(input t_q v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sh0000_0000_8000_0000) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    logic [31:0] r_focal_x, r_focal_y, r_cx, r_cy;
    logic [31:0] r_k1, r_k2, r_k3, r_p1, r_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x <= 32'd32768000;
            r_focal_y <= 32'd32768000;
            r_cx      <= '0;
            r_cy      <= '0;
            r_k1      <= '0;
            r_k2      <= '0;
            r_k3      <= '0;
            r_p1      <= '0;
            r_p2      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FOCAL_X:   r_focal_x <= i_cfg_data[31:0];
                CFG_FOCAL_Y:   r_focal_y <= i_cfg_data[31:0];
                CFG_PRINCIPAL: begin
                    r_cx <= i_cfg_data[63:32];
                    r_cy <= i_cfg_data[31:0];
                end
                CFG_K1:        r_k1 <= i_cfg_data[31:0];
                CFG_K2:        r_k2 <= i_cfg_data[31:0];
                CFG_K3:        r_k3 <= i_cfg_data[31:0];
                CFG_P1:        r_p1 <= i_cfg_data[31:0];
                CFG_P2:        r_p2 <= i_cfg_data[31:0];
            endcase
        end
    end

    logic en;
    logic m6_vld;
    logic r_out_valid;
    t_ldm_out r_out_data;

    assign en         = !(r_out_valid && i_out_stall) || !m6_vld;
    assign o_in_stall = !en;

    // normalize
    t_d               dx, dy;
    t_d   [1:0]       div_d;
    logic [1:0][31:0] div_f;
    t_q   [1:0]       div_q;
    logic [1:0]       div_sat;
    logic             div_vld;

    assign dx = t_d'(i_in_data.point_x) - t_d'({2'b00, r_cx});
    assign dy = t_d'(i_in_data.point_y) - t_d'({2'b00, r_cy});
    assign div_d[0] = dx;
    assign div_d[1] = dy;
    assign div_f[0] = r_focal_x;
    assign div_f[1] = r_focal_y;

    ldm_div #(.LANES(2)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid && en),
        .i_d     (div_d),
        .i_f     (div_f),
        .o_valid (div_vld),
        .o_q     (div_q),
        .o_sat   (div_sat)
    );

    // pass 1: xx, yy, xy
    localparam int S1_W = 1 + 2 * 64;
    t_q   [2:0]      m1_a, m1_b, m1_p;
    logic [2:0]      m1_sat;
    logic            m1_vld;
    logic [S1_W-1:0] m1_side;
    logic            m1_s_sat;
    t_q              m1_s_x, m1_s_y;

    assign m1_a[0] = div_q[0];
    assign m1_b[0] = div_q[0];
    assign m1_a[1] = div_q[1];
    assign m1_b[1] = div_q[1];
    assign m1_a[2] = div_q[0];
    assign m1_b[2] = div_q[1];

    ldm_qmul #(.LANES(3), .SIDE_W(S1_W)) u_m1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (div_vld),
        .i_a (m1_a), .i_b (m1_b), .i_side ({|div_sat, div_q[0], div_q[1]}),
        .o_valid (m1_vld), .o_p (m1_p), .o_sat (m1_sat), .o_side (m1_side)
    );
    assign {m1_s_sat, m1_s_x, m1_s_y} = m1_side;

    t_qres a1_r2, a1_xx2, a1_yy2;
    logic  r_a1_vld, r_a1_sat;
    t_q    r_a1_r2, r_a1_xx2, r_a1_yy2, r_a1_xy, r_a1_x, r_a1_y;

    assign a1_r2  = qadd(m1_p[0], m1_p[1]);
    assign a1_xx2 = qadd(m1_p[0], m1_p[0]);
    assign a1_yy2 = qadd(m1_p[1], m1_p[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1_vld <= 1'b0;
        end else if (en) begin
            r_a1_vld <= m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1_sat <= m1_s_sat | (|m1_sat) | a1_r2.sat | a1_xx2.sat | a1_yy2.sat;
            r_a1_r2  <= a1_r2.val;
            r_a1_xx2 <= a1_xx2.val;
            r_a1_yy2 <= a1_yy2.val;
            r_a1_xy  <= m1_p[2];
            r_a1_x   <= m1_s_x;
            r_a1_y   <= m1_s_y;
        end
    end

    // pass 2: r2*k3, 2p1*xy, 2p2*xy
    localparam int S2_W = 1 + 5 * 64;
    t_q   [2:0]      m2_a, m2_b, m2_p;
    logic [2:0]      m2_sat;
    logic            m2_vld;
    logic [S2_W-1:0] m2_side;
    logic            m2_s_sat;
    t_q              m2_s_r2, m2_s_xx2, m2_s_yy2, m2_s_x, m2_s_y;

    assign m2_a[0] = r_a1_r2;
    assign m2_b[0] = coef_q(r_k3);
    assign m2_a[1] = coef_q2(r_p1);
    assign m2_b[1] = r_a1_xy;
    assign m2_a[2] = coef_q2(r_p2);
    assign m2_b[2] = r_a1_xy;

    ldm_qmul #(.LANES(3), .SIDE_W(S2_W)) u_m2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r_a1_vld),
        .i_a (m2_a), .i_b (m2_b),
        .i_side ({r_a1_sat, r_a1_r2, r_a1_xx2, r_a1_yy2, r_a1_x, r_a1_y}),
        .o_valid (m2_vld), .o_p (m2_p), .o_sat (m2_sat), .o_side (m2_side)
    );
    assign {m2_s_sat, m2_s_r2, m2_s_xx2, m2_s_yy2, m2_s_x, m2_s_y} = m2_side;

    t_qres a2_h1, a2_tsx, a2_tsy;
    logic  r_a2_vld, r_a2_sat;
    t_q    r_a2_h1, r_a2_tsx, r_a2_tsy, r_a2_pxy1, r_a2_pxy2, r_a2_r2, r_a2_x, r_a2_y;

    assign a2_h1  = qadd(coef_q(r_k2), m2_p[0]);
    assign a2_tsx = qadd(m2_s_r2, m2_s_xx2);
    assign a2_tsy = qadd(m2_s_r2, m2_s_yy2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a2_vld <= 1'b0;
        end else if (en) begin
            r_a2_vld <= m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a2_sat  <= m2_s_sat | (|m2_sat) | a2_h1.sat | a2_tsx.sat | a2_tsy.sat;
            r_a2_h1   <= a2_h1.val;
            r_a2_tsx  <= a2_tsx.val;
            r_a2_tsy  <= a2_tsy.val;
            r_a2_pxy1 <= m2_p[1];
            r_a2_pxy2 <= m2_p[2];
            r_a2_r2   <= m2_s_r2;
            r_a2_x    <= m2_s_x;
            r_a2_y    <= m2_s_y;
        end
    end

    // pass 3: r2*h1, p2*(r2+2xx), p1*(r2+2yy)
    localparam int S3_W = 1 + 5 * 64;
    t_q   [2:0]      m3_a, m3_b, m3_p;
    logic [2:0]      m3_sat;
    logic            m3_vld;
    logic [S3_W-1:0] m3_side;
    logic            m3_s_sat;
    t_q              m3_s_r2, m3_s_x, m3_s_y, m3_s_pxy1, m3_s_pxy2;

    assign m3_a[0] = r_a2_r2;
    assign m3_b[0] = r_a2_h1;
    assign m3_a[1] = coef_q(r_p2);
    assign m3_b[1] = r_a2_tsx;
    assign m3_a[2] = coef_q(r_p1);
    assign m3_b[2] = r_a2_tsy;

    ldm_qmul #(.LANES(3), .SIDE_W(S3_W)) u_m3 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r_a2_vld),
        .i_a (m3_a), .i_b (m3_b),
        .i_side ({r_a2_sat, r_a2_r2, r_a2_x, r_a2_y, r_a2_pxy1, r_a2_pxy2}),
        .o_valid (m3_vld), .o_p (m3_p), .o_sat (m3_sat), .o_side (m3_side)
    );
    assign {m3_s_sat, m3_s_r2, m3_s_x, m3_s_y, m3_s_pxy1, m3_s_pxy2} = m3_side;

    t_qres a3_h2, a3_tx, a3_ty;
    logic  r_a3_vld, r_a3_sat;
    t_q    r_a3_h2, r_a3_tx, r_a3_ty, r_a3_r2, r_a3_x, r_a3_y;

    assign a3_h2 = qadd(coef_q(r_k1), m3_p[0]);
    assign a3_tx = qadd(m3_s_pxy1, m3_p[1]);
    assign a3_ty = qadd(m3_p[2], m3_s_pxy2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a3_vld <= 1'b0;
        end else if (en) begin
            r_a3_vld <= m3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a3_sat <= m3_s_sat | (|m3_sat) | a3_h2.sat | a3_tx.sat | a3_ty.sat;
            r_a3_h2  <= a3_h2.val;
            r_a3_tx  <= a3_tx.val;
            r_a3_ty  <= a3_ty.val;
            r_a3_r2  <= m3_s_r2;
            r_a3_x   <= m3_s_x;
            r_a3_y   <= m3_s_y;
        end
    end

    // pass 4: r2*h2
    localparam int S4_W = 1 + 4 * 64;
    t_q   [0:0]      m4_a, m4_b, m4_p;
    logic [0:0]      m4_sat;
    logic            m4_vld;
    logic [S4_W-1:0] m4_side;
    logic            m4_s_sat;
    t_q              m4_s_x, m4_s_y, m4_s_tx, m4_s_ty;

    assign m4_a[0] = r_a3_r2;
    assign m4_b[0] = r_a3_h2;

    ldm_qmul #(.LANES(1), .SIDE_W(S4_W)) u_m4 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r_a3_vld),
        .i_a (m4_a), .i_b (m4_b),
        .i_side ({r_a3_sat, r_a3_x, r_a3_y, r_a3_tx, r_a3_ty}),
        .o_valid (m4_vld), .o_p (m4_p), .o_sat (m4_sat), .o_side (m4_side)
    );
    assign {m4_s_sat, m4_s_x, m4_s_y, m4_s_tx, m4_s_ty} = m4_side;

    t_qres a4_poly;
    logic  r_a4_vld, r_a4_sat;
    t_q    r_a4_poly, r_a4_x, r_a4_y, r_a4_tx, r_a4_ty;

    assign a4_poly = qadd(Q_ONE, m4_p[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a4_vld <= 1'b0;
        end else if (en) begin
            r_a4_vld <= m4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a4_sat  <= m4_s_sat | m4_sat[0] | a4_poly.sat;
            r_a4_poly <= a4_poly.val;
            r_a4_x    <= m4_s_x;
            r_a4_y    <= m4_s_y;
            r_a4_tx   <= m4_s_tx;
            r_a4_ty   <= m4_s_ty;
        end
    end

    // pass 5: x*poly, y*poly
    localparam int S5_W = 1 + 2 * 64;
    t_q   [1:0]      m5_a, m5_b, m5_p;
    logic [1:0]      m5_sat;
    logic            m5_vld;
    logic [S5_W-1:0] m5_side;
    logic            m5_s_sat;
    t_q              m5_s_tx, m5_s_ty;

    assign m5_a[0] = r_a4_x;
    assign m5_b[0] = r_a4_poly;
    assign m5_a[1] = r_a4_y;
    assign m5_b[1] = r_a4_poly;

    ldm_qmul #(.LANES(2), .SIDE_W(S5_W)) u_m5 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r_a4_vld),
        .i_a (m5_a), .i_b (m5_b), .i_side ({r_a4_sat, r_a4_tx, r_a4_ty}),
        .o_valid (m5_vld), .o_p (m5_p), .o_sat (m5_sat), .o_side (m5_side)
    );
    assign {m5_s_sat, m5_s_tx, m5_s_ty} = m5_side;

    t_qres a5_xd, a5_yd;
    logic  r_a5_vld, r_a5_sat;
    t_q    r_a5_xd, r_a5_yd;

    assign a5_xd = qadd(m5_p[0], m5_s_tx);
    assign a5_yd = qadd(m5_p[1], m5_s_ty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a5_vld <= 1'b0;
        end else if (en) begin
            r_a5_vld <= m5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a5_sat <= m5_s_sat | (|m5_sat) | a5_xd.sat | a5_yd.sat;
            r_a5_xd  <= a5_xd.val;
            r_a5_yd  <= a5_yd.val;
        end
    end

    // pass 6: back to pixels
    t_q   [1:0] m6_a, m6_b, m6_p;
    logic [1:0] m6_sat;
    logic       m6_s_sat;

    assign m6_a[0] = r_a5_xd;
    assign m6_b[0] = t_q'({32'b0, r_focal_x});
    assign m6_a[1] = r_a5_yd;
    assign m6_b[1] = t_q'({32'b0, r_focal_y});

    ldm_qmul #(.LANES(2), .SIDE_W(1)) u_m6 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r_a5_vld),
        .i_a (m6_a), .i_b (m6_b), .i_side (r_a5_sat),
        .o_valid (m6_vld), .o_p (m6_p), .o_sat (m6_sat), .o_side (m6_s_sat)
    );

    // output register
    t_q          px, py;
    logic [32:0] ox, oy;

    assign px = m6_p[0] + t_q'({32'b0, r_cx});
    assign py = m6_p[1] + t_q'({32'b0, r_cy});
    assign ox = to_out(px);
    assign oy = to_out(py);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= m6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out_data.distorted_x <= ox[31:0];
            r_out_data.distorted_y <= oy[31:0];
            r_out_data.saturated   <= m6_s_sat | (|m6_sat) | ox[32] | oy[32];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- design/ldm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the lens distortion point mapper, bound to the top level
`include "lens_distortion_point_mapper_macros.svh"

module ldm_checker
    import ldm_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_ldm_out o_out_data
);

    // no output beat right after reset
    `LDM_ASSERT_NEXT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n, !o_out_valid)

    // input back-pressure only comes from a held output beat
    `LDM_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // a held output beat keeps its payload
    `LDM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data))

    // valid input with an empty output: next cycle, input free or output valid
    `LDM_ASSERT_NEXT(a_free_flow, i_clk, i_rst_n, !o_out_valid && i_in_valid,
        !o_in_stall || o_out_valid)

endmodule

bind lens_distortion_point_mapper ldm_checker u_ldm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- tb/sv/lens_distortion_point_mapper_tb.sv -----
`timescale 1ns / 1ps
// Testbench: lens_distortion_point_mapper against a bit-exact distortion predictor
module lens_distortion_point_mapper_tb;
    import ldm_pkg::*;

    localparam longint FX_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam longint FX_ONE = 64'sh0000_0001_0000_0000;
    localparam int     CYCLE_LIMIT = 1500000;
    localparam int     TAIL_CYCLES = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_ldm_in     i_in_data;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_ldm_out    o_out_data;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    lens_distortion_point_mapper u_top (.*);

    logic [63:0] calib [8];
    t_ldm_out    pending_pts [$];
    int          err_cnt;
    int          pts_sent;
    int          pts_checked;
    int          sat_seen;
    int          cfg_writes;
    int          cyc;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_len;
    int          hold_left;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, pending_pts.size());
            $display("lens_distortion_point_mapper_tb NOT OK");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic longint lim_clamp(input longint v, ref bit sat);
        if (v > FX_LIM) begin
            sat = 1'b1;
            return FX_LIM;
        end
        if (v < -FX_LIM) begin
            sat = 1'b1;
            return -FX_LIM;
        end
        return v;
    endfunction

    function automatic longint sat_add(input longint a, input longint b, ref bit sat);
        return lim_clamp(a + b, sat);
    endfunction

    function automatic longint fx_mul(input longint a, input longint b, ref bit sat);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  r;
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        p  = ({64'd0, ua} * {64'd0, ub}) >> 32;
        r  = p[63:0];
        if (p[127:64] != 0 || r > 64'(FX_LIM)) begin
            sat = 1'b1;
            r   = 64'(FX_LIM);
        end
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint norm_coord(input longint d, input logic [63:0] f,
                                          ref bit sat);
        logic [63:0] m;
        logic [63:0] num;
        logic [63:0] q1;
        logic [63:0] r1;
        logic [63:0] q;
        m = (d < 0) ? 64'(-d) : 64'(d);
        if (f == 0) f = 64'd1;
        num = m << 31;
        q1  = num / f;
        r1  = num % f;
        if (q1 > 64'(FX_LIM / 2)) begin
            sat = 1'b1;
            q   = 64'(FX_LIM);
        end else begin
            q = 2 * q1 + (r1 << 1) / f;
        end
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] to_pixel(input longint v, ref bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            v   = 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            v   = -64'sd2147483648;
        end
        return v[31:0];
    endfunction

    function automatic longint coef(input logic [63:0] r);
        return longint'($signed(r[31:0])) * 256;
    endfunction

    function automatic t_ldm_out distort_point(input t_ldm_in pt);
        bit          sat;
        logic [63:0] fx, fy;
        longint      cx, cy, k1, k2, k3, p1, p2;
        longint      x, y, xx, yy, xy, r2, h, poly, tx, ty, xd, yd;
        t_ldm_out    res;
        sat = 1'b0;
        fx = {32'd0, calib[CFG_FOCAL_X][31:0]};
        fy = {32'd0, calib[CFG_FOCAL_Y][31:0]};
        cx = longint'({32'd0, calib[CFG_PRINCIPAL][63:32]});
        cy = longint'({32'd0, calib[CFG_PRINCIPAL][31:0]});
        k1 = coef(calib[CFG_K1]);
        k2 = coef(calib[CFG_K2]);
        k3 = coef(calib[CFG_K3]);
        p1 = coef(calib[CFG_P1]);
        p2 = coef(calib[CFG_P2]);
        x  = norm_coord(longint'(pt.point_x) - cx, fx, sat);
        y  = norm_coord(longint'(pt.point_y) - cy, fy, sat);
        xx = fx_mul(x, x, sat);
        yy = fx_mul(y, y, sat);
        xy = fx_mul(x, y, sat);
        r2 = sat_add(xx, yy, sat);
        h    = sat_add(k2, fx_mul(r2, k3, sat), sat);
        h    = sat_add(k1, fx_mul(r2, h, sat), sat);
        poly = sat_add(FX_ONE, fx_mul(r2, h, sat), sat);
        tx = sat_add(fx_mul(2 * p1, xy, sat),
                     fx_mul(p2, sat_add(r2, sat_add(xx, xx, sat), sat), sat), sat);
        ty = sat_add(fx_mul(p1, sat_add(r2, sat_add(yy, yy, sat), sat), sat),
                     fx_mul(2 * p2, xy, sat), sat);
        xd = sat_add(fx_mul(x, poly, sat), tx, sat);
        yd = sat_add(fx_mul(y, poly, sat), ty, sat);
        res.distorted_x = to_pixel(fx_mul(xd, longint'(fx), sat) + cx, sat);
        res.distorted_y = to_pixel(fx_mul(yd, longint'(fy), sat) + cy, sat);
        res.saturated   = sat;
        return res;
    endfunction

    // ---------------- result checker / receiver ----------------
    always @(posedge i_clk) begin
        t_ldm_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pts.size() == 0) begin
                $display("%0t unexpected beat, actual %h", $time, o_out_data);
                err_cnt++;
            end else begin
                want = pending_pts.pop_front();
                pts_checked++;
                if (want.saturated) sat_seen++;
                if (o_out_data.distorted_x !== want.distorted_x) begin
                    $display("%0t distorted_x expected %h actual %h",
                             $time, want.distorted_x, o_out_data.distorted_x);
                    err_cnt++;
                end
                if (o_out_data.distorted_y !== want.distorted_y) begin
                    $display("%0t distorted_y expected %h actual %h",
                             $time, want.distorted_y, o_out_data.distorted_y);
                    err_cnt++;
                end
                if (o_out_data.saturated !== want.saturated) begin
                    $display("%0t saturated expected %b actual %b",
                             $time, want.saturated, o_out_data.saturated);
                    err_cnt++;
                end
            end
        end
        if (hold_len != 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic send_point(input logic [31:0] px, input logic [31:0] py);
        t_ldm_in pt;
        int      gap;
        pt.point_x = px;
        pt.point_y = py;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= pt;
        do @(posedge i_clk); while (o_in_stall);
        pending_pts = {pending_pts, distort_point(pt)};
        pts_sent++;
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_calib(input t_cfg_idx idx, input logic [63:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        calib[idx] = (idx == CFG_PRINCIPAL) ? val : {32'd0, val[31:0]};
        cfg_writes++;
    endtask

    task automatic set_lens(input logic [31:0] fx, input logic [31:0] fy,
                            input logic [63:0] pp, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3,
                            input logic [31:0] p1, input logic [31:0] p2);
        write_calib(CFG_FOCAL_X, {32'd0, fx});
        write_calib(CFG_FOCAL_Y, {32'd0, fy});
        write_calib(CFG_PRINCIPAL, pp);
        write_calib(CFG_K1, {32'd0, k1});
        write_calib(CFG_K2, {32'd0, k2});
        write_calib(CFG_K3, {32'd0, k3});
        write_calib(CFG_P1, {32'd0, p1});
        write_calib(CFG_P2, {32'd0, p2});
    endtask

    function automatic logic [31:0] small_coef(input int span);
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    task automatic random_lens;
        logic [31:0] cx, cy;
        cx = $urandom_range(2000) << 16 | $urandom_range(16'hFFFF);
        cy = $urandom_range(1200) << 16 | $urandom_range(16'hFFFF);
        set_lens(($urandom_range(2000) + 100) << 16 | $urandom_range(16'hFFFF),
                 ($urandom_range(2000) + 100) << 16 | $urandom_range(16'hFFFF),
                 {cx, cy},
                 small_coef(1 << 23), small_coef(1 << 22), small_coef(1 << 21),
                 small_coef(1 << 18), small_coef(1 << 18));
    endtask

    task automatic random_point;
        logic [31:0] px, py;
        if ($urandom_range(9) < 7) begin
            px = calib[CFG_PRINCIPAL][63:32] + small_coef(32'h0800_0000);
            py = calib[CFG_PRINCIPAL][31:0] + small_coef(32'h0800_0000);
        end else begin
            px = $urandom;
            py = $urandom;
        end
        send_point(px, py);
    endtask

    // ---------------- tests ----------------
    task automatic test_directed;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_point(32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'hFFFF_FFFF, 32'h0001_0000);
        set_lens(32'h0001_0000, 32'hFFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h0, 32'h0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'h0000_0001);
        send_point(32'h0010_0000, 32'hFFF0_0000);
        // zero focal length acts as one LSB
        set_lens(32'h0, 32'h0, 64'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_point(32'h0, 32'h0);
        send_point(32'h0000_0001, 32'hFFFF_FFFF);
        send_point(32'h0001_0000, 32'h0001_0000);
        // mild lens, output in range
        set_lens(32'd500 << 16, 32'd480 << 16, {32'd320 << 16, 32'd240 << 16},
                 32'hFF80_0000, 32'h0020_0000, 32'hFFF0_0000,
                 32'h0001_0000, 32'hFFFF_0000);
        send_point(32'd320 << 16, 32'd240 << 16);
        send_point(32'd0, 32'd0);
        send_point(32'd640 << 16, 32'd480 << 16);
        send_point(32'd100 << 16, 32'd400 << 16);
        drain();
    endtask

    task automatic test_random_phases;
        int pct_send [4];
        int pct_recv [4];
        pct_send = '{0, 79, 0, 7};
        pct_recv = '{0, 0, 79, 7};
        for (int ph = 0; ph < 4; ph++) begin
            for (int cfg_set = 0; cfg_set < 4; cfg_set++) begin
                drain();
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                random_lens();
                send_idle_pct  = pct_send[ph];
                recv_stall_pct = pct_recv[ph];
                repeat (55) random_point();
            end
        end
        drain();
    endtask

    task automatic test_backpressure;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len = 400;
        repeat (150) random_point();
        drain();
    endtask

    initial begin
        err_cnt = 0;
        pts_sent = 0;
        pts_checked = 0;
        sat_seen = 0;
        cfg_writes = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        calib = '{64'd32768000, 64'd32768000, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0};
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_FOCAL_X;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phases();
        test_backpressure();

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d points (%0d checked, %0d saturated) over %0d register writes",
                 pts_sent, pts_checked, sat_seen, cfg_writes);
        $display("idle/stall phases, extreme calibrations and a long output hold-off");
        if (err_cnt == 0 && pending_pts.size() == 0) begin
            $display("lens_distortion_point_mapper_tb OK");
        end else begin
            $display("lens_distortion_point_mapper_tb NOT OK");
        end
        $finish;
    end

endmodule
